// ===== hw/rtl/pfvc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfvc_pkg: shared types and constants of the palette framebuffer video card
// Word structs of both channels, decoded command types and register offsets.
// ----------------------------------------------------------------------------
package pfvc_pkg;

	localparam int unsigned VRAM_BYTES    = 524288;
	localparam int unsigned ACTIVE_WIDTH  = 640;
	localparam int unsigned ACTIVE_HEIGHT = 480;

	localparam int unsigned VRAM_WORDS = VRAM_BYTES / 4;
	localparam int unsigned VWW        = $clog2(VRAM_WORDS);
	localparam int unsigned BAW        = 21;
	localparam int unsigned LINE_BASE  = 32'h20;

	localparam logic [16:0] REG_MODE      = 17'h00001;
	localparam logic [16:0] REG_PAL_INDEX = 17'h05038;
	localparam logic [16:0] REG_PAL_DATA  = 17'h05039;
	localparam logic [16:0] REG_IRQ_EN    = 17'h08000;
	localparam logic [16:0] REG_IRQ_DIS   = 17'h08001;
	localparam logic [16:0] REG_STATUS    = 17'(32'h10010 / 4);

	localparam logic [31:0] MODE_WORD_1BPP = 32'h20000000;
	localparam logic [31:0] MODE_WORD_2BPP = 32'h40000000;
	localparam logic [31:0] MODE_WORD_4BPP = 32'h80000000;
	localparam logic [31:0] MODE_WORD_8BPP = 32'h00010000;

	localparam logic [2:0] FUNC_REG_WR  = 3'd0;
	localparam logic [2:0] FUNC_REG_RD  = 3'd1;
	localparam logic [2:0] FUNC_VRAM_WR = 3'd2;
	localparam logic [2:0] FUNC_VRAM_RD = 3'd3;
	localparam logic [2:0] FUNC_VBLANK  = 3'd4;
	localparam logic [2:0] FUNC_PIXEL   = 3'd5;

	typedef struct packed {
		logic [2:0]  func;
		logic [16:0] word_offset;
		logic [31:0] write_data;
		logic [31:0] byte_mask;
		logic [9:0]  pixel_x;
		logic [8:0]  pixel_y;
	} pfvc_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic [7:0]  pixel_red;
		logic [7:0]  pixel_green;
		logic [7:0]  pixel_blue;
	} pfvc_out_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_REG_WR,
		OP_REG_RD,
		OP_VRAM_WR,
		OP_VRAM_RD,
		OP_VBLANK,
		OP_PIXEL
	} op_t;

	typedef enum logic [2:0] {
		RW_NONE,
		RW_MODE,
		RW_PAL_INDEX,
		RW_PAL_DATA,
		RW_IRQ_EN,
		RW_IRQ_DIS
	} rw_t;

	typedef struct packed {
		op_t         op;
		rw_t         rw;
		logic        is_status;
		logic        in_area;
		logic [16:0] word_offset;
		logic [31:0] write_data;
		logic [31:0] byte_mask;
		logic [9:0]  pixel_x;
		logic [8:0]  pixel_y;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_VRD,
		ST_PAL,
		ST_OUT
	} back_st_t;

endpackage

// ===== hw/rtl/pfvc_front.sv =====
// ----------------------------------------------------------------------------
// pfvc_front: request decode and command queue
// Accepts request words, decodes them into commands and holds up to two.
// ----------------------------------------------------------------------------
module pfvc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pfvc_pkg::pfvc_in_t req,
	input  logic               clearing,
	output logic               q_valid,
	output pfvc_pkg::cmd_t     q_cmd,
	input  logic               pop
);
	import pfvc_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       dec;
	logic       push;

	always_comb begin
		dec = '0;
		dec.word_offset = req.word_offset;
		dec.write_data  = req.write_data;
		dec.byte_mask   = req.byte_mask;
		dec.pixel_x     = req.pixel_x;
		dec.pixel_y     = req.pixel_y;
		dec.is_status   = (req.word_offset == REG_STATUS);
		dec.in_area     = (32'(req.pixel_x) < ACTIVE_WIDTH) && (32'(req.pixel_y) < ACTIVE_HEIGHT);
		dec.rw          = RW_NONE;
		case (req.word_offset)
			REG_MODE:      dec.rw = RW_MODE;
			REG_PAL_INDEX: dec.rw = RW_PAL_INDEX;
			REG_PAL_DATA:  dec.rw = RW_PAL_DATA;
			REG_IRQ_EN:    dec.rw = RW_IRQ_EN;
			REG_IRQ_DIS:   dec.rw = RW_IRQ_DIS;
			default:       dec.rw = RW_NONE;
		endcase
		case (req.func)
			FUNC_REG_WR:  dec.op = OP_REG_WR;
			FUNC_REG_RD:  dec.op = OP_REG_RD;
			FUNC_VRAM_WR: dec.op = OP_VRAM_WR;
			FUNC_VRAM_RD: dec.op = OP_VRAM_RD;
			FUNC_VBLANK:  dec.op = OP_VBLANK;
			FUNC_PIXEL:   dec.op = OP_PIXEL;
			default:      dec.op = OP_NONE;
		endcase
	end

	// No word is taken while video memory is still being cleared.
	assign req_stall = (count_q == 2'd2) || clearing;
	assign push      = req_valid && !req_stall;
	assign q_valid   = (count_q != 2'd0);
	assign q_cmd     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hw/rtl/pfvc_back.sv =====
// ----------------------------------------------------------------------------
// pfvc_back: command execution
// Holds the registers, video memory and palette, runs one command at a time
// and presents its response word.
// ----------------------------------------------------------------------------
module pfvc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  pfvc_pkg::cmd_t      q_cmd,
	output logic                pop,
	output logic                clearing,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pfvc_pkg::pfvc_out_t rsp
);
	import pfvc_pkg::*;

	localparam logic [VWW-1:0] CLR_LAST = VWW'(VRAM_WORDS - 1);

	logic [31:0] vram [VRAM_WORDS];
	logic [23:0] pal  [256];

	back_st_t     state_q, state_d;
	logic [VWW-1:0] clr_cnt_q;
	cmd_t         cmd_s1;
	logic [1:0]   mode_q;
	logic [7:0]   pidx_q;
	logic [1:0]   ccnt_q;
	logic [7:0]   cbyte_q [2];
	logic         vdis_q;
	logic         irq_q;
	logic         tog_q;
	logic [255:0] pal_valid_q;
	logic [1:0]   lane_q;
	logic [7:0]   pix_idx_q;
	logic [31:0]  vram_rd_q;
	logic [23:0]  pal_rd_q;
	logic [31:0]  rd_q;
	logic [23:0]  rgb_q;

	logic           exec;
	logic [VWW:0]   off_ext;
	logic [VWW-1:0] off_word;
	logic [BAW-1:0] pix_addr_raw;
	logic [BAW-1:0] pix_addr;
	logic [VWW-1:0] vram_ra;
	logic           vram_we;
	logic [VWW-1:0] vram_wa;
	logic [31:0]    vram_wd;
	logic [7:0]     cur_byte;
	logic [7:0]     pal_ra;
	logic           pal_we;
	logic [23:0]    pal_wd;
	logic [7:0]     new_byte;
	logic [31:0]    inv_data;

	function automatic logic [VWW-1:0] vram_ra_hold();
		logic [VWW:0] e;
		e = (VWW+1)'(cmd_s1.word_offset);
		if (32'(e) >= VRAM_WORDS) begin
			e = e - (VWW+1)'(VRAM_WORDS);
		end
		return e[VWW-1:0];
	endfunction

	assign exec     = (state_q == ST_IDLE) && q_valid;
	assign inv_data = ~q_cmd.write_data;
	assign new_byte = inv_data[31:24];

	// Offsets stay below twice the memory size, so one subtract wraps them.
	always_comb begin
		off_ext = (VWW+1)'(q_cmd.word_offset);
		if (32'(off_ext) >= VRAM_WORDS) begin
			off_ext = off_ext - (VWW+1)'(VRAM_WORDS);
		end
		off_word = off_ext[VWW-1:0];
	end

	// A line starts at LINE_BASE with a stride of 128 bytes times 2^mode.
	always_comb begin
		pix_addr_raw = BAW'(LINE_BASE)
			+ (BAW'(q_cmd.pixel_y) << (7 + mode_q))
			+ BAW'(q_cmd.pixel_x >> (2'd3 - mode_q));
		pix_addr = pix_addr_raw;
		if (32'(pix_addr_raw) >= VRAM_BYTES) begin
			pix_addr = pix_addr_raw - BAW'(VRAM_BYTES);
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			vram_ra = clr_cnt_q;
		end else if (q_cmd.op == OP_PIXEL) begin
			vram_ra = VWW'(pix_addr >> 2);
		end else begin
			vram_ra = off_word;
		end
	end

	always_comb begin
		vram_we = 1'b0;
		vram_wa = off_word;
		vram_wd = '0;
		if (state_q == ST_CLEAR) begin
			vram_we = 1'b1;
			vram_wa = clr_cnt_q;
		end else if (state_q == ST_VRD && cmd_s1.op == OP_VRAM_WR) begin
			vram_we = 1'b1;
			vram_wa = vram_ra_hold();
			vram_wd = (vram_rd_q & ~cmd_s1.byte_mask) | (~cmd_s1.write_data & cmd_s1.byte_mask);
		end
	end

	// Pixels come from the byte MSB first.
	always_comb begin
		cur_byte = 8'(vram_rd_q >> (5'd8 * (5'd3 - 5'(lane_q))));
		case (mode_q)
			2'd0:    pal_ra = 8'((cur_byte >> (3'd7 - cmd_s1.pixel_x[2:0])) & 8'h01);
			2'd1:    pal_ra = 8'((cur_byte >> (3'd6 - {cmd_s1.pixel_x[1:0], 1'b0})) & 8'h03);
			2'd2:    pal_ra = 8'((cur_byte >> (cmd_s1.pixel_x[0] ? 3'd0 : 3'd4)) & 8'h0f);
			default: pal_ra = cur_byte;
		endcase
	end

	assign pal_we = exec && q_cmd.op == OP_REG_WR && q_cmd.rw == RW_PAL_DATA
		&& ccnt_q == 2'd2;
	assign pal_wd = {cbyte_q[0], cbyte_q[1], new_byte};

	always_ff @(posedge clk) begin
		if (vram_we) begin
			vram[vram_wa] <= vram_wd;
		end
		vram_rd_q <= vram[vram_ra];
	end

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal[pidx_q] <= pal_wd;
		end
		pal_rd_q <= pal[pal_ra];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						OP_VRAM_WR, OP_VRAM_RD: state_d = ST_VRD;
						OP_PIXEL: state_d = q_cmd.in_area ? ST_VRD : ST_OUT;
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_VRD: state_d = (cmd_s1.op == OP_PIXEL) ? ST_PAL : ST_OUT;
			ST_PAL: state_d = ST_OUT;
			ST_OUT: begin
				if (!rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop             = exec;
		clearing        = (state_q == ST_CLEAR);
		rsp_valid       = (state_q == ST_OUT);
		rsp.read_data   = rd_q;
		rsp.irq_level   = irq_q;
		rsp.pixel_red   = rgb_q[23:16];
		rsp.pixel_green = rgb_q[15:8];
		rsp.pixel_blue  = rgb_q[7:0];
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			cmd_s1    <= q_cmd;
			lane_q    <= pix_addr[1:0];
			rd_q      <= '0;
			rgb_q     <= '0;
			if (q_cmd.op == OP_REG_WR && q_cmd.rw == RW_PAL_DATA && ccnt_q != 2'd2) begin
				cbyte_q[ccnt_q[0]] <= new_byte;
			end
			if (q_cmd.op == OP_REG_RD && q_cmd.is_status) begin
				rd_q <= {14'd0, 1'b1, !tog_q, 16'd0};
			end
		end
		if (state_q == ST_VRD) begin
			pix_idx_q <= pal_ra;
			if (cmd_s1.op == OP_VRAM_RD) begin
				rd_q <= ~vram_rd_q;
			end
		end
		if (state_q == ST_PAL) begin
			if (pal_valid_q[pix_idx_q]) begin
				rgb_q <= pal_rd_q;
			end else begin
				rgb_q <= (pix_idx_q == 8'd0) ? 24'hffffff : 24'h000000;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			mode_q      <= 2'd0;
			pidx_q      <= 8'd0;
			ccnt_q      <= 2'd0;
			vdis_q      <= 1'b1;
			irq_q       <= 1'b0;
			tog_q       <= 1'b0;
			pal_valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (pal_we) begin
				pal_valid_q[pidx_q] <= 1'b1;
			end
			if (exec) begin
				case (q_cmd.op)
					OP_REG_WR: begin
						case (q_cmd.rw)
							RW_MODE: begin
								if (inv_data == MODE_WORD_1BPP) begin
									mode_q <= 2'd0;
								end else if (inv_data == MODE_WORD_2BPP) begin
									mode_q <= 2'd1;
								end else if (inv_data == MODE_WORD_4BPP) begin
									mode_q <= 2'd2;
								end else if (inv_data == MODE_WORD_8BPP) begin
									mode_q <= 2'd3;
								end
							end
							RW_PAL_INDEX: pidx_q <= new_byte;
							RW_PAL_DATA: begin
								if (ccnt_q == 2'd2) begin
									ccnt_q <= 2'd0;
									pidx_q <= pidx_q + 8'd1;
								end else begin
									ccnt_q <= ccnt_q + 2'd1;
								end
							end
							RW_IRQ_EN: begin
								vdis_q <= 1'b0;
								irq_q  <= 1'b0;
							end
							RW_IRQ_DIS: vdis_q <= 1'b1;
							default: ;
						endcase
					end
					OP_REG_RD: begin
						if (q_cmd.is_status) begin
							tog_q <= !tog_q;
						end
					end
					OP_VBLANK: begin
						if (!vdis_q) begin
							irq_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== hw/rtl/palette_framebuffer_video_card.sv =====
// ----------------------------------------------------------------------------
// palette_framebuffer_video_card: framebuffer video card with RGB palette
// Register window, video memory access, vertical-blank interrupt and pixel
// scan-out through a 256-entry palette.
// ----------------------------------------------------------------------------
// After reset the card clears its video memory, one word per cycle, and
// stalls requests until that is done. Register accesses, ticks and pixels
// outside the active area then pass from idle straight to the response state,
// video memory reads and writes go through a memory read state first, and a
// pixel fetch goes through the registered read of the video memory followed
// by the registered palette read. A two-word queue takes new requests while a
// response waits to be taken.
module palette_framebuffer_video_card (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pfvc_pkg::pfvc_in_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pfvc_pkg::pfvc_out_t rsp
);
	import pfvc_pkg::*;

	logic q_valid;
	cmd_t q_cmd;
	logic pop;
	logic clearing;

	pfvc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.clearing  (clearing),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop)
	);

	pfvc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== dv/palette_framebuffer_video_card_test.sv =====
// ----------------------------------------------------------------------------
// palette_framebuffer_video_card_test: self-checking bench for the video card
// Random and directed requests are driven with random idling on both sides;
// every response word is compared field by field with a built-in predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module palette_framebuffer_video_card_test;
	import pfvc_pkg::*;

	localparam int WATCHDOG_CYCLES = 400000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	pfvc_in_t  req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b1;
	pfvc_out_t rsp;

	palette_framebuffer_video_card dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// Predictor state of the card.
	logic [31:0] vram_model [VRAM_WORDS];
	logic [23:0] palette_model [256];
	logic [1:0]  depth_model;
	logic [7:0]  pal_index_model;
	logic [1:0]  colour_count_model;
	logic [7:0]  colour_model [3];
	logic        vblank_off_model;
	logic        irq_model;
	logic        toggle_model;

	pfvc_in_t  pending_words[$];
	pfvc_out_t expected_words[$];
	int        errors = 0;
	bit        stim_done = 1'b0;
	bit        quiet = 1'b0;
	int        hold_off = 0;
	bit        hold_started = 1'b0;

	function automatic logic [23:0] pixel_colour(logic [9:0] x, logic [8:0] y);
		logic [31:0] stride, b, shift, bits, addr, byte_val;
		if (x >= ACTIVE_WIDTH || y >= ACTIVE_HEIGHT)
			return 24'h0;
		stride = 32'd128 << depth_model;
		case (depth_model)
			2'd0: begin b = x >> 3; shift = 7 - (x & 7); bits = 1; end
			2'd1: begin b = x >> 2; shift = 6 - 2 * (x & 3); bits = 3; end
			2'd2: begin b = x >> 1; shift = 4 - 4 * (x & 1); bits = 15; end
			default: begin b = x; shift = 0; bits = 255; end
		endcase
		addr = (LINE_BASE + y * stride + b) % VRAM_BYTES;
		byte_val = (vram_model[(addr >> 2) % VRAM_WORDS] >> (8 * (3 - (addr & 3)))) & 8'hff;
		return palette_model[(byte_val >> shift) & bits];
	endfunction

	function automatic pfvc_out_t card_response(pfvc_in_t w);
		pfvc_out_t   r;
		logic [31:0] d;
		logic [16:0] idx;
		r = '0;
		d = ~w.write_data;
		idx = 17'(w.word_offset % VRAM_WORDS);
		case (w.func)
			FUNC_REG_WR: begin
				case (w.word_offset)
					REG_MODE: begin
						if (d == MODE_WORD_1BPP) depth_model = 2'd0;
						else if (d == MODE_WORD_2BPP) depth_model = 2'd1;
						else if (d == MODE_WORD_4BPP) depth_model = 2'd2;
						else if (d == MODE_WORD_8BPP) depth_model = 2'd3;
					end
					REG_PAL_INDEX: pal_index_model = d[31:24];
					REG_PAL_DATA: begin
						colour_model[colour_count_model] = d[31:24];
						if (colour_count_model == 2'd2) begin
							palette_model[pal_index_model] =
								{colour_model[0], colour_model[1], colour_model[2]};
							pal_index_model = pal_index_model + 8'd1;
							colour_count_model = 2'd0;
						end else begin
							colour_count_model = colour_count_model + 2'd1;
						end
					end
					REG_IRQ_EN: begin vblank_off_model = 1'b0; irq_model = 1'b0; end
					REG_IRQ_DIS: vblank_off_model = 1'b1;
					default: ;
				endcase
			end
			FUNC_REG_RD: begin
				if (w.word_offset == REG_STATUS) begin
					toggle_model = ~toggle_model;
					r.read_data = (32'(toggle_model) << 16) | (32'd1 << 17);
				end
			end
			FUNC_VRAM_WR:
				vram_model[idx] = (vram_model[idx] & ~w.byte_mask) | (d & w.byte_mask);
			FUNC_VRAM_RD: r.read_data = ~vram_model[idx];
			FUNC_VBLANK: if (!vblank_off_model) irq_model = 1'b1;
			FUNC_PIXEL: {r.pixel_red, r.pixel_green, r.pixel_blue} =
				pixel_colour(w.pixel_x, w.pixel_y);
			default: ;
		endcase
		r.irq_level = irq_model;
		return r;
	endfunction

	function automatic pfvc_in_t make_word(logic [2:0] f, logic [16:0] off, logic [31:0] d);
		pfvc_in_t w;
		w.func = f;
		w.word_offset = off;
		w.write_data = d;
		w.byte_mask = {$urandom};
		w.pixel_x = 10'($urandom_range(0, 1023));
		w.pixel_y = 9'($urandom_range(0, 511));
		return w;
	endfunction

	function automatic pfvc_in_t random_word();
		pfvc_in_t    w;
		logic [16:0] off;
		w = make_word(3'($urandom_range(0, 7)), 17'($urandom), $urandom);
		case ($urandom_range(0, 19))
			0, 1: begin w.func = FUNC_REG_WR; w.word_offset = REG_MODE;
				case ($urandom_range(0, 4))
					0: w.write_data = ~MODE_WORD_1BPP;
					1: w.write_data = ~MODE_WORD_2BPP;
					2: w.write_data = ~MODE_WORD_4BPP;
					3: w.write_data = ~MODE_WORD_8BPP;
					default: ;
				endcase
			end
			2: begin w.func = FUNC_REG_WR; w.word_offset = REG_PAL_INDEX; end
			3, 4: begin w.func = FUNC_REG_WR; w.word_offset = REG_PAL_DATA; end
			5: begin w.func = FUNC_REG_WR;
				w.word_offset = $urandom_range(0, 1) ? REG_IRQ_EN : REG_IRQ_DIS; end
			6, 7: begin w.func = $urandom_range(0, 1) ? FUNC_VBLANK : FUNC_REG_RD;
				w.word_offset = REG_STATUS; end
			8, 9, 10: begin w.func = $urandom_range(0, 1) ? FUNC_VRAM_WR : FUNC_VRAM_RD;
				// Mostly hit the first few lines so pixel fetches see written data.
				off = 17'($urandom_range(0, 2047));
				if ($urandom_range(0, 3) != 0) w.word_offset = off;
			end
			11, 12, 13, 14, 15, 16: begin w.func = FUNC_PIXEL;
				if ($urandom_range(0, 3) != 0) begin
					w.pixel_x = 10'($urandom_range(0, ACTIVE_WIDTH - 1));
					w.pixel_y = 9'($urandom_range(0, 15));
				end
			end
			default: ;
		endcase
		return w;
	endfunction

	initial begin
		pfvc_in_t w;
		int n;
		for (int i = 0; i < VRAM_WORDS; i++) vram_model[i] = '0;
		for (int i = 0; i < 256; i++) palette_model[i] = '0;
		palette_model[0] = 24'hffffff;
		depth_model = '0; pal_index_model = '0; colour_count_model = '0;
		colour_model[0] = '0; colour_model[1] = '0; colour_model[2] = '0;
		vblank_off_model = 1'b1; irq_model = 1'b0; toggle_model = 1'b0;

		// Directed part: extremes, every func, palette wrap, irq paths.
		pending_words.push_back(make_word(FUNC_VBLANK, '0, '0));
		pending_words.push_back(make_word(FUNC_REG_WR, REG_IRQ_EN, '0));
		pending_words.push_back(make_word(FUNC_VBLANK, '0, '0));
		pending_words.push_back(make_word(FUNC_REG_WR, REG_IRQ_DIS, '1));
		pending_words.push_back(make_word(FUNC_VBLANK, '0, '0));
		pending_words.push_back(make_word(FUNC_REG_RD, REG_STATUS, '0));
		pending_words.push_back(make_word(FUNC_REG_RD, REG_STATUS, '0));
		pending_words.push_back(make_word(FUNC_REG_RD, '1, '0));
		pending_words.push_back(make_word(FUNC_REG_WR, REG_PAL_INDEX, 32'h00ffffff));
		for (int i = 0; i < 6; i++)
			pending_words.push_back(make_word(FUNC_REG_WR, REG_PAL_DATA, $urandom));
		w = make_word(FUNC_VRAM_WR, 17'h8, '0); w.byte_mask = '1;
		pending_words.push_back(w);
		w = make_word(FUNC_VRAM_WR, '1, 32'h12345678); w.byte_mask = '1;
		pending_words.push_back(w);
		pending_words.push_back(make_word(FUNC_VRAM_RD, '1, '0));
		pending_words.push_back(make_word(FUNC_REG_WR, REG_MODE, ~MODE_WORD_8BPP));
		w = make_word(FUNC_PIXEL, '0, '0); w.pixel_x = '0; w.pixel_y = '0;
		pending_words.push_back(w);
		w.pixel_x = 10'(ACTIVE_WIDTH - 1); w.pixel_y = 9'(ACTIVE_HEIGHT - 1);
		pending_words.push_back(w);
		w.pixel_x = '1; w.pixel_y = '1;
		pending_words.push_back(w);
		pending_words.push_back(make_word(FUNC_REG_WR, REG_MODE, 32'h0));
		pending_words.push_back(make_word(3'd6, '0, '0));
		pending_words.push_back(make_word(3'd7, '1, '1));

		n = 0;
		while (n < 1050) begin
			if (pending_words.size() < 8) begin
				w = random_word();
				pending_words.push_back(w);
				n++;
				if (n == 900) quiet = 1'b1;
			end else begin
				@(posedge clk);
			end
		end
		wait (pending_words.size() == 0);
		stim_done = 1'b1;
	end

	// Driver.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				expected_words.push_back(card_response(req));
			if (req_valid && req_stall) begin
				// Hold the word.
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				req_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 14);
				req_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				req <= pending_words.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Monitor and receiver stall. The long hold-off starts once the clearing
	// pass is over and the card first stops stalling requests.
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		pfvc_out_t e;
		if (!arst_n) begin
			rsp_stall <= 1'b1;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected response %h", $time, rsp);
					errors++;
				end else begin
					e = expected_words.pop_front();
					if (rsp.read_data !== e.read_data)
						$display("%0t: read_data expected %h actual %h", $time,
							e.read_data, rsp.read_data);
					if (rsp.irq_level !== e.irq_level)
						$display("%0t: irq_level expected %b actual %b", $time,
							e.irq_level, rsp.irq_level);
					if (rsp.pixel_red !== e.pixel_red)
						$display("%0t: pixel_red expected %h actual %h", $time,
							e.pixel_red, rsp.pixel_red);
					if (rsp.pixel_green !== e.pixel_green)
						$display("%0t: pixel_green expected %h actual %h", $time,
							e.pixel_green, rsp.pixel_green);
					if (rsp.pixel_blue !== e.pixel_blue)
						$display("%0t: pixel_blue expected %h actual %h", $time,
							e.pixel_blue, rsp.pixel_blue);
					if (rsp !== e) errors++;
				end
			end
			if (!hold_started && !req_stall) begin
				hold_started <= 1'b1;
				hold_off <= 60;
				rsp_stall <= 1'b1;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				rsp_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				rsp_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(0, 14);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog: covers the clearing pass after reset as well.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done && !req_valid && expected_words.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
